// ===== rtl/vfd_pkg.sv =====
// Package: word layout constants and bit-position helpers for the VFD scanner.
`default_nettype none

package vfd_pkg;

  localparam int WORD_W = 56;
  localparam int GRID_W = 5;
  localparam int ROW_W  = 3;
  localparam int KEY_W  = 4;
  localparam int POS_W  = 6;

  localparam int FRAME_BYTES_DEF = 63;
  localparam int PIXEL_ROWS_DEF  = 7;
  localparam int GRID_COUNT_DEF  = 18;
  localparam int KEY_STROBES_DEF = 4;

  // Rows of the upper anode bank run downward with the leftmost column highest.
  localparam int UPPER_ROWS = 4;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ROWS = 2'b10
  } vfd_state_t;

  function automatic logic [POS_W-1:0] grid_bit_pos(input logic [GRID_W-1:0] g);
    logic [POS_W-1:0] pos;
    if (g < 5'd16) begin
      pos = 6'd40 + {2'b00, g[3:0]};
    end else if (g == 5'd16) begin
      pos = 6'd5;
    end else begin
      pos = 6'd4;
    end
    return pos;
  endfunction

  // Lowest anode bit of a pixel row's four-bit group.
  function automatic logic [POS_W-1:0] anode_base(input logic [ROW_W-1:0] row);
    logic [POS_W-1:0] pos;
    if (row < 3'(UPPER_ROWS)) begin
      pos = 6'd36 - {1'b0, row, 2'b00};
    end else begin
      pos = 6'd12 + {1'b0, row - 3'(UPPER_ROWS), 2'b00};
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vfd_grid_scan_with_key_matrix.sv =====
// Top level: multiplexed VFD grid scanner with key matrix strobe and frame memory.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  command   | start, busy            | kind, byte_address, byte_value,
//            |                        | key1_pressed, key2_pressed, driver_busy
//  result    | done (one-cycle pulse) | segment_word, key_code
//
// A write item or a skipped tick (driver_busy) keeps busy low.
// During a scan tick, one frame memory read is issued per pixel row on the single
// read port, and the shared nibble placer merges each row in the next cycle; done
// pulses as the block returns to idle.
// Synchronous reset clears all control state and the frame memory valid bits, so the
// frame reads as blank at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module vfd_grid_scan_with_key_matrix
  import vfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int PIXEL_ROWS  = PIXEL_ROWS_DEF,
  parameter int GRID_COUNT  = GRID_COUNT_DEF,
  parameter int KEY_STROBES = KEY_STROBES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              kind,
  input  wire logic [5:0]        byte_address,
  input  wire logic [7:0]        byte_value,
  input  wire logic              key1_pressed,
  input  wire logic              key2_pressed,
  input  wire logic              driver_busy,
  output logic                   done,
  output logic [WORD_W-1:0]      segment_word,
  output logic [KEY_W-1:0]       key_code
);

  localparam int ROW_STRIDE = GRID_COUNT / 2;
  localparam int AW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int RA_W       = AW + 1;

  // Sequencer and scan state
  vfd_state_t        state, state_next;
  logic [GRID_W-1:0] grid_index, grid_next;
  logic [1:0]        key_strobe_index, strobe_next;
  logic [KEY_W-1:0]  held_key_code, held_next;
  logic [WORD_W-1:0] word;
  logic [ROW_W-1:0]  issue_row;
  logic [ROW_W-1:0]  rd_row;
  logic              rd_vld;
  logic [RA_W-1:0]   rd_addr;

  // Frame memory
  logic [7:0]             mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] mem_valid;
  logic [7:0]             rd_data;
  logic                   rd_ok;

  logic tick_go, wr_go, rd_en, last_merge;
  logic [RA_W-1:0]   wr_addr_ext;
  logic [WORD_W-1:0] tick_word, placed;
  logic [3:0]        nib, nib_placed;
  logic [2:0]        strobe_inc;
  logic [GRID_W-1:0] grid_inc;
  logic [KEY_W-1:0]  code;

  assign busy    = (state != S_IDLE);
  assign tick_go = start && !busy && kind && !driver_busy;
  assign wr_go   = start && !busy && !kind;
  assign wr_addr_ext = RA_W'(byte_address);

  // Key scan: line one wins, release clears only the code owned by this strobe.
  always_comb begin
    strobe_inc = {1'b0, key_strobe_index} + 3'd1;
    if (key1_pressed) begin
      code = KEY_W'(strobe_inc);
    end else if (key2_pressed) begin
      code = KEY_W'(KEY_STROBES) + KEY_W'(strobe_inc);
    end else begin
      code = '0;
    end
    held_next = held_key_code;
    if (code != '0) begin
      held_next = code;
    end else if (held_key_code == KEY_W'(strobe_inc) ||
                 held_key_code == KEY_W'(strobe_inc) + KEY_W'(KEY_STROBES)) begin
      held_next = '0;
    end
    strobe_next = (strobe_inc >= 3'(KEY_STROBES)) ? 2'd0 : strobe_inc[1:0];

    grid_inc  = grid_index + 5'd1;
    grid_next = (grid_inc >= GRID_W'(GRID_COUNT)) ? '0 : grid_inc;

    tick_word = (WORD_W'(1) << (6'd8 + {4'b0000, strobe_next}))
              | (WORD_W'(1) << grid_bit_pos(grid_next));
  end

  // Shared nibble placer: pick the grid's nibble, orient it, shift it into the row's slot.
  always_comb begin
    nib = '0;
    if (rd_ok) begin
      nib = grid_index[0] ? rd_data[7:4] : rd_data[3:0];
    end
    nib_placed = (rd_row < 3'(UPPER_ROWS)) ? {nib[0], nib[1], nib[2], nib[3]} : nib;
    placed     = WORD_W'(nib_placed) << anode_base(rd_row);
  end

  assign rd_en      = (state == S_ROWS) && (issue_row < ROW_W'(PIXEL_ROWS));
  assign last_merge = rd_vld && (rd_row == ROW_W'(PIXEL_ROWS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_go) state_next = S_ROWS;
      end
      S_ROWS: begin
        if (last_merge) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      grid_index       <= '0;
      key_strobe_index <= '0;
      held_key_code    <= '0;
      issue_row        <= '0;
      rd_vld           <= 1'b0;
      done             <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= (state == S_ROWS) && last_merge;
      rd_vld <= rd_en;
      if (tick_go) begin
        grid_index       <= grid_next;
        key_strobe_index <= strobe_next;
        held_key_code    <= held_next;
        issue_row        <= '0;
      end else if (rd_en) begin
        issue_row <= issue_row + 3'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (tick_go) begin
      word    <= tick_word;
      rd_addr <= RA_W'(grid_next[GRID_W-1:1]);
    end else begin
      if (rd_en) begin
        rd_addr <= rd_addr + RA_W'(ROW_STRIDE);
        rd_row  <= issue_row;
      end
      if (rd_vld) begin
        word <= word | placed;
      end
    end
    if (last_merge) begin
      segment_word <= word | placed;
      key_code     <= held_key_code;
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_go && wr_addr_ext < RA_W'(FRAME_BYTES)) begin
      mem[byte_address] <= byte_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

  // Valid bits stand for the cleared frame: an unwritten byte reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_go && wr_addr_ext < RA_W'(FRAME_BYTES)) begin
        mem_valid[byte_address] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= (rd_addr < RA_W'(FRAME_BYTES)) && mem_valid[rd_addr[AW-1:0]];
      end
    end
  end

  // Checks
  a_done_after_rows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_ROWS))
    else $error("done without a finished row sweep");

  a_no_read_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_en)
    else $error("frame read issued while idle");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (key_code <= KEY_W'(2 * KEY_STROBES)))
    else $error("key code out of range");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_row <= ROW_W'(PIXEL_ROWS))
    else $error("row issue counter overran");

endmodule

`default_nettype wire
